FILE: design/rti_pkg.sv
// Shared widths, types and codes for the ray/triangle intersection pipeline.
package rti_pkg;

    // coordinate format
    localparam int CW   = 32;               // coordinate width
    localparam int FB   = 16;               // fraction bits

    // front end widths
    localparam int EW   = CW + 1;           // edge and origin offset
    localparam int PRW  = 2 * EW;           // one cross product term
    localparam int CRW  = PRW + 1;          // cross term difference
    localparam int NW   = CRW - FB;         // normal component after rescale
    localparam int NLW  = NW / 2;           // low (unsigned) slice of a normal component
    localparam int NHW  = NW - NLW;         // high (signed) slice
    localparam int DENW = NW + CW + 2;      // n.dir
    localparam int NUMW = NW + EW + 2;      // n.(a - origin)
    localparam int DMW  = DENW - 1;         // |n.dir|
    localparam int NMW  = NUMW - 1;         // |n.(a - origin)|

    // divider widths; t is capped once the point is sure to clamp
    localparam int QW   = CW + FB + 2;      // quotient bits kept
    localparam int QLW  = QW / 2;
    localparam int QHW  = QW - QLW;
    localparam int NNW  = NMW + FB;         // dividend |num| << FB
    localparam int RW   = DENW;             // partial remainder
    localparam int OVW  = DMW + QW - FB;    // overflow compare width

    // back end widths
    localparam int MW   = CW + QW + 1;      // dir * t
    localparam int SCW  = MW - FB;          // dir * t rescaled
    localparam int SMW  = SCW + 1;          // origin + rescaled step
    localparam int PIW  = CW + 2;           // point clamped to +-2^CW
    localparam int UW   = CW + 3;           // projected vertex minus point
    localparam int XW   = 2 * UW + 1;       // crossing abscissa term

    // stream and configuration port widths
    localparam int DW_IN   = ((9 * CW + 7) / 8) * 8;
    localparam int DW_OUT  = ((3 * CW + 1 + 7) / 8) * 8;
    localparam int CFG_AW  = 3;

    localparam logic [CW-1:0] DIR_Z_RST = {{(CW-FB){1'b1}}, {FB{1'b0}}};

    // configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5
    } t_reg;

    // axis dropped by the projection
    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } t_axis;

    typedef struct packed {
        logic [2:0][CW-1:0] org;
        logic [2:0][CW-1:0] dir;
    } t_ray;

    // per triangle data carried past the front end
    typedef struct packed {
        logic               den_zero;
        logic               sgn_diff;
        t_axis              ax;
        logic [2:0][CW-1:0] pu;
        logic [2:0][CW-1:0] pw;
    } t_geo;

    function automatic logic signed [EW-1:0] sx(input logic [CW-1:0] a);
        return {a[CW-1], a};
    endfunction

endpackage

FILE: design/rti_front.sv
// Front end: edges, face normal, dominant axis, n.dir and n.(a - origin).
module rti_front
    import rti_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [DW_IN-1:0]  i_data,
    input  t_ray              i_ray,
    output logic              o_vld,
    output t_geo              o_geo,
    output logic [NMW-1:0]    o_nmag,
    output logic [DMW-1:0]    o_dmag
);

    logic [6:0] r_vld;

    logic [CW-1:0]          v_in [9];
    logic signed [EW-1:0]   r1_e1 [3];
    logic signed [EW-1:0]   r1_e2 [3];
    logic signed [EW-1:0]   r1_dv [3];
    logic [CW-1:0]          r1_v  [9];

    logic signed [PRW-1:0]  r2_pa [3];
    logic signed [PRW-1:0]  r2_pb [3];
    logic signed [EW-1:0]   r2_dv [3];
    logic [CW-1:0]          r2_v  [9];

    logic signed [CRW-1:0]  c3  [3];
    logic signed [CRW-1:0]  cb3 [3];
    logic signed [NW-1:0]   r3_n  [3];
    logic signed [EW-1:0]   r3_dv [3];
    logic [CW-1:0]          r3_v  [9];

    logic [NW-1:0]          an [3];
    t_axis                  ax4;
    logic signed [NLW+CW:0]      r4_dl [3];
    logic signed [NHW+CW-1:0]    r4_dh [3];
    logic signed [NLW+EW:0]      r4_vl [3];
    logic signed [NHW+EW-1:0]    r4_vh [3];
    t_axis                  r4_ax;
    logic [2:0][CW-1:0]     r4_pu;
    logic [2:0][CW-1:0]     r4_pw;

    logic signed [DENW-1:0] r5_td [3];
    logic signed [NUMW-1:0] r5_tv [3];
    t_axis                  r5_ax;
    logic [2:0][CW-1:0]     r5_pu;
    logic [2:0][CW-1:0]     r5_pw;

    logic signed [DENW-1:0] r6_den;
    logic signed [NUMW-1:0] r6_num;
    t_axis                  r6_ax;
    logic [2:0][CW-1:0]     r6_pu;
    logic [2:0][CW-1:0]     r6_pw;

    t_geo                   r7_geo;
    logic [NMW-1:0]         r7_nmag;
    logic [DMW-1:0]         r7_dmag;

    // advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_vld};
        end
    end

    // unpack the word: vertex a x in the lowest bits
    always_comb begin
        for (int idx = 0; idx < 9; idx++) begin
            v_in[idx] = i_data[idx*CW +: CW];
        end
    end

    // stage 1: edges and origin offset
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_e1[k] <= sx(v_in[3+k]) - sx(v_in[k]);
                r1_e2[k] <= sx(v_in[6+k]) - sx(v_in[k]);
                r1_dv[k] <= sx(v_in[k]) - sx(i_ray.org[k]);
            end
            r1_v <= v_in;
        end
    end

    // stage 2: cross product terms
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r2_pa[k] <= r1_e1[(k+1)%3] * r1_e2[(k+2)%3];
                r2_pb[k] <= r1_e1[(k+2)%3] * r1_e2[(k+1)%3];
            end
            r2_dv <= r1_dv;
            r2_v  <= r1_v;
        end
    end

    // stage 3: normal, rescaled with truncation toward zero
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c3[k]  = {r2_pa[k][PRW-1], r2_pa[k]} - {r2_pb[k][PRW-1], r2_pb[k]};
            cb3[k] = c3[k] + {{(CRW-FB){1'b0}}, {FB{c3[k][CRW-1]}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r3_n[k] <= NW'(cb3[k] >>> FB);
            end
            r3_dv <= r2_dv;
            r3_v  <= r2_v;
        end
    end

    // stage 4: dominant axis, projection and split dot product terms
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            an[k] = r3_n[k][NW-1] ? NW'(-r3_n[k]) : NW'(r3_n[k]);
        end
        if (an[0] >= an[1] && an[0] >= an[2]) begin
            ax4 = AX_X;
        end else if (an[1] >= an[2]) begin
            ax4 = AX_Y;
        end else begin
            ax4 = AX_Z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r4_dl[k] <= $signed({1'b0, r3_n[k][NLW-1:0]}) * $signed(i_ray.dir[k]);
                r4_dh[k] <= $signed(r3_n[k][NW-1:NLW]) * $signed(i_ray.dir[k]);
                r4_vl[k] <= $signed({1'b0, r3_n[k][NLW-1:0]}) * r3_dv[k];
                r4_vh[k] <= $signed(r3_n[k][NW-1:NLW]) * r3_dv[k];
            end
            for (int i = 0; i < 3; i++) begin
                case (ax4)
                    AX_X: begin
                        r4_pu[i] <= r3_v[3*i+1];
                        r4_pw[i] <= r3_v[3*i+2];
                    end
                    AX_Y: begin
                        r4_pu[i] <= r3_v[3*i];
                        r4_pw[i] <= r3_v[3*i+2];
                    end
                    default: begin
                        r4_pu[i] <= r3_v[3*i];
                        r4_pw[i] <= r3_v[3*i+1];
                    end
                endcase
            end
            r4_ax <= ax4;
        end
    end

    // stage 5: join the partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r5_td[k] <= (DENW'(r4_dh[k]) <<< NLW) + DENW'(r4_dl[k]);
                r5_tv[k] <= (NUMW'(r4_vh[k]) <<< NLW) + NUMW'(r4_vl[k]);
            end
            r5_ax <= r4_ax;
            r5_pu <= r4_pu;
            r5_pw <= r4_pw;
        end
    end

    // stage 6: sum the dot products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_den <= r5_td[0] + r5_td[1] + r5_td[2];
            r6_num <= r5_tv[0] + r5_tv[1] + r5_tv[2];
            r6_ax  <= r5_ax;
            r6_pu  <= r5_pu;
            r6_pw  <= r5_pw;
        end
    end

    // stage 7: magnitudes and sign flags for the divider
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_dmag         <= r6_den[DENW-1] ? DMW'(-r6_den) : DMW'(r6_den);
            r7_nmag         <= r6_num[NUMW-1] ? NMW'(-r6_num) : NMW'(r6_num);
            r7_geo.den_zero <= (r6_den == '0);
            r7_geo.sgn_diff <= r6_den[DENW-1] ^ r6_num[NUMW-1];
            r7_geo.ax       <= r6_ax;
            r7_geo.pu       <= r6_pu;
            r7_geo.pw       <= r6_pw;
        end
    end

    assign o_vld  = r_vld[6];
    assign o_geo  = r7_geo;
    assign o_nmag = r7_nmag;
    assign o_dmag = r7_dmag;

endmodule

FILE: design/rti_div.sv
// Pipelined restoring divider: t = |num| * 2^FB / |den|, one quotient bit a stage.
module rti_div
    import rti_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  t_geo            i_geo,
    input  logic [NMW-1:0]  i_nmag,
    input  logic [DMW-1:0]  i_dmag,
    output logic            o_vld,
    output t_geo            o_geo,
    output logic [QW-1:0]   o_q
);

    logic [QW:0]      r_vld;
    logic [QW:0]      r_ovf;
    logic [RW-1:0]    r_rem [QW+1];
    logic [NNW-1:0]   r_num [QW+1];
    logic [DMW-1:0]   r_den [QW+1];
    logic [QW-1:0]    r_quo [QW+1];
    t_geo             r_geo [QW+1];

    logic [NNW-1:0]   dvd;

    assign dvd = NNW'(i_nmag) << FB;

    // advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QW-1:0], i_vld};
        end
    end

    // entry: flag quotients past the kept range, load the top dividend bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= OVW'(i_nmag) >= (OVW'(i_dmag) << (QW - FB));
            r_num[0] <= dvd;
            r_rem[0] <= RW'(dvd >> QW);
            r_den[0] <= i_dmag;
            r_quo[0] <= '0;
            r_geo[0] <= i_geo;
        end
    end

    // one trial subtract per stage, most significant quotient bit first
    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [RW-1:0] trial;
        logic [RW:0]   diff;

        assign trial = {r_rem[s][RW-2:0], r_num[s][QW-1-s]};
        assign diff  = {1'b0, trial} - {1'b0, RW'(r_den[s])};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= diff[RW] ? trial : diff[RW-1:0];
                r_quo[s+1] <= {r_quo[s][QW-2:0], ~diff[RW]};
                r_num[s+1] <= r_num[s];
                r_den[s+1] <= r_den[s];
                r_ovf[s+1] <= r_ovf[s];
                r_geo[s+1] <= r_geo[s];
            end
        end
    end

    assign o_vld = r_vld[QW];
    assign o_geo = r_geo[QW];
    assign o_q   = r_ovf[QW] ? {QW{1'b1}} : r_quo[QW];

endmodule

FILE: design/rti_point.sv
// Back end: intersection point, crossing count and the result register.
module rti_point
    import rti_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  t_geo              i_geo,
    input  logic [QW-1:0]     i_q,
    input  t_ray              i_ray,
    output logic              o_vld,
    output logic [DW_OUT-1:0] o_data
);

    localparam logic signed [SMW-1:0] LIM_HI = SMW'(1) << CW;
    localparam logic signed [SMW-1:0] LIM_LO = -LIM_HI;
    localparam logic signed [PIW-1:0] OMAX   = (PIW'(1) << (CW - 1)) - PIW'(1);
    localparam logic signed [PIW-1:0] OMIN   = -OMAX - PIW'(1);

    logic [6:0] r_vld;

    logic signed [CW+QLW:0]   r1_pl [3];
    logic signed [CW+QHW:0]   r1_ph [3];
    logic [6:1]               r_miss;
    t_axis                    r_ax [1:5];
    logic [2:0][CW-1:0]       r_pu [1:4];
    logic [2:0][CW-1:0]       r_pw [1:4];

    logic signed [MW-1:0]     r2_m [3];

    logic signed [MW-1:0]     cb3 [3];
    logic signed [SCW-1:0]    r3_sc [3];

    logic signed [SMW-1:0]    sum4 [3];
    logic signed [PIW-1:0]    r4_pi [3];

    logic signed [PIW-1:0]    a0;
    logic signed [PIW-1:0]    a1;
    logic signed [UW-1:0]     r5_u [3];
    logic signed [UW-1:0]     r5_w [3];
    logic signed [PIW-1:0]    r5_pi [3];

    logic signed [2*UW-1:0]   r6_uw [3];
    logic signed [2*UW-1:0]   r6_wu [3];
    logic [2:0]               r6_upos;
    logic [2:0]               r6_wneg;
    logic signed [PIW-1:0]    r6_pi [3];

    logic signed [XW-1:0]     cr [3];
    logic [2:0]               cnt;
    logic                     hit;
    logic signed [PIW-1:0]    oc [3];
    logic [DW_OUT-1:0]        n_data;
    logic [DW_OUT-1:0]        r7_data;

    // advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_vld};
        end
    end

    // carry the miss flag and the projection down the stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_miss[1] <= i_geo.den_zero | ((i_q != '0) & i_geo.sgn_diff);
            r_miss[6:2] <= r_miss[5:1];
            r_ax[1] <= i_geo.ax;
            r_pu[1] <= i_geo.pu;
            r_pw[1] <= i_geo.pw;
            for (int st = 2; st <= 5; st++) begin
                r_ax[st] <= r_ax[st-1];
            end
            for (int st = 2; st <= 4; st++) begin
                r_pu[st] <= r_pu[st-1];
                r_pw[st] <= r_pw[st-1];
            end
        end
    end

    // stage 1: dir * t in two partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_pl[k] <= $signed(i_ray.dir[k]) * $signed({1'b0, i_q[QLW-1:0]});
                r1_ph[k] <= $signed(i_ray.dir[k]) * $signed({1'b0, i_q[QW-1:QLW]});
            end
        end
    end

    // stage 2: join the partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r2_m[k] <= (MW'(r1_ph[k]) <<< QLW) + MW'(r1_pl[k]);
            end
        end
    end

    // stage 3: rescale with truncation toward zero
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cb3[k] = r2_m[k] + {{(MW-FB){1'b0}}, {FB{r2_m[k][MW-1]}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r3_sc[k] <= SCW'(cb3[k] >>> FB);
            end
        end
    end

    // stage 4: add the origin and clamp the point to +-2^CW
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum4[k] = SMW'(r3_sc[k]) + SMW'($signed(i_ray.org[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                if (sum4[k] > LIM_HI) begin
                    r4_pi[k] <= PIW'(LIM_HI);
                end else if (sum4[k] < LIM_LO) begin
                    r4_pi[k] <= PIW'(LIM_LO);
                end else begin
                    r4_pi[k] <= PIW'(sum4[k]);
                end
            end
        end
    end

    // stage 5: move the projected vertices so the point sits at the origin
    always_comb begin
        case (r_ax[4])
            AX_X: begin
                a0 = r4_pi[1];
                a1 = r4_pi[2];
            end
            AX_Y: begin
                a0 = r4_pi[0];
                a1 = r4_pi[2];
            end
            default: begin
                a0 = r4_pi[0];
                a1 = r4_pi[1];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r5_u[i] <= UW'($signed(r_pu[4][i])) - UW'(a0);
                r5_w[i] <= UW'($signed(r_pw[4][i])) - UW'(a1);
            end
            r5_pi <= r4_pi;
        end
    end

    // stage 6: cross terms of each edge and the side flags
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r6_uw[i]   <= r5_u[i] * r5_w[(i+1)%3];
                r6_wu[i]   <= r5_w[i] * r5_u[(i+1)%3];
                r6_upos[i] <= ~r5_u[i][UW-1] & (r5_u[i] != '0);
                r6_wneg[i] <= r5_w[i][UW-1];
            end
            r6_pi <= r5_pi;
        end
    end

    // stage 7: count crossings of the positive u half axis and build the word
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cr[i]  = XW'(r6_uw[i]) - XW'(r6_wu[i]);
            cnt[i] = (r6_wneg[i] != r6_wneg[(i+1)%3])
                   & ((r6_upos[i] & r6_upos[(i+1)%3])
                   | ((r6_upos[i] | r6_upos[(i+1)%3])
                   & (cr[i] != '0) & (cr[i][XW-1] == r6_wneg[(i+1)%3])));
        end
        hit = ~r_miss[6] & (^cnt);
        for (int k = 0; k < 3; k++) begin
            if (r6_pi[k] > OMAX) begin
                oc[k] = OMAX;
            end else if (r6_pi[k] < OMIN) begin
                oc[k] = OMIN;
            end else begin
                oc[k] = r6_pi[k];
            end
        end
        n_data = '0;
        n_data[0] = hit;
        if (hit) begin
            for (int k = 0; k < 3; k++) begin
                n_data[1 + k*CW +: CW] = oc[k][CW-1:0];
            end
        end
    end

    // result register; hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_data <= n_data;
        end
    end

    assign o_vld  = r_vld[6];
    assign o_data = r7_data;

endmodule

FILE: design/ray_triangle_intersection.sv
// Top level of the ray/triangle intersection pipeline.
//
// Tests one triangle per word against a ray held in six registers.
// Input stream: one word per triangle, nine signed Q16.16 coordinates.
// Output stream: one word per triangle with the hit flag and the point.
// Configuration: write the ray's origin and direction through the write port
// while no triangle is in flight; unknown indexes are ignored.
// Pipeline: 7 stages of normal and dot products, 51 divider stages (an entry
// stage, then one quotient bit per stage for t), 7 stages for the point and the
// crossing count.
// Throughput: one triangle per cycle while no result waits on a low tready.
// Reset: all words in flight are dropped, the ray returns to origin zero and
// direction (0, 0, -1.0).
// Stall: while a result waits on a low tready the whole pipeline holds, and
// tready on the input side drops until the result is taken.
module ray_triangle_intersection
    import rti_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
    input  logic [DW_IN-1:0]  i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // hit, hit_x, hit_y, hit_z from bit 0 up, zero padded
    output logic [DW_OUT-1:0] o_m_axis_tdata,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CW-1:0]     i_cfg_data
);

    t_ray            r_ray;
    logic            en;

    logic            f_vld;
    t_geo            f_geo;
    logic [NMW-1:0]  f_nmag;
    logic [DMW-1:0]  f_dmag;
    logic            d_vld;
    t_geo            d_geo;
    logic [QW-1:0]   d_q;
    logic            p_vld;
    logic [DW_OUT-1:0] p_data;

    // ray registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ray.org    <= '0;
            r_ray.dir[0] <= '0;
            r_ray.dir[1] <= '0;
            r_ray.dir[2] <= DIR_Z_RST;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_addr))
                REG_ORIGIN_X: r_ray.org[0] <= i_cfg_data;
                REG_ORIGIN_Y: r_ray.org[1] <= i_cfg_data;
                REG_ORIGIN_Z: r_ray.org[2] <= i_cfg_data;
                REG_DIR_X:    r_ray.dir[0] <= i_cfg_data;
                REG_DIR_Y:    r_ray.dir[1] <= i_cfg_data;
                REG_DIR_Z:    r_ray.dir[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance the pipeline unless a result waits on the receiver
    assign en = ~p_vld | i_m_axis_tready;

    rti_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_axis_tvalid),
        .i_data  (i_s_axis_tdata),
        .i_ray   (r_ray),
        .o_vld   (f_vld),
        .o_geo   (f_geo),
        .o_nmag  (f_nmag),
        .o_dmag  (f_dmag)
    );

    rti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_geo   (f_geo),
        .i_nmag  (f_nmag),
        .i_dmag  (f_dmag),
        .o_vld   (d_vld),
        .o_geo   (d_geo),
        .o_q     (d_q)
    );

    rti_point u_point (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (d_vld),
        .i_geo   (d_geo),
        .i_q     (d_q),
        .i_ray   (r_ray),
        .o_vld   (p_vld),
        .o_data  (p_data)
    );

    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = p_vld;
    assign o_m_axis_tdata  = p_data;

    // input side stalls only behind a result that is not taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without a waiting result");

    // a miss carries a zero point
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[0]) |-> (o_m_axis_tdata[DW_OUT-1:1] == '0))
        else $error("miss word with nonzero point");

    // reset empties the pipeline
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result word present right after reset");

endmodule

FILE: verif/ray_triangle_intersection_test.sv
// Self-checking testbench for the ray/triangle intersection pipeline.
module ray_triangle_intersection_test;
    import rti_pkg::*;

    typedef struct {
        logic              hit;
        logic signed [31:0] px, py, pz;
    } t_hit_word;

    localparam logic [CFG_AW-1:0] CFG_ADDR_UNUSED = 3'd6;
    localparam longint RUN_LIMIT = 1000000;

    // Hold the ray copy and the words still owed by the block
    class t_hit_scoreboard;
        logic signed [31:0] ray[6];
        t_hit_word          owed[$];
        int                 errors;

        function new();
            foreach (ray[i]) ray[i] = '0;
            ray[REG_DIR_Z] = DIR_Z_RST;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_AW-1:0] idx, logic [CW-1:0] val);
            if (idx <= REG_DIR_Z) ray[idx] = val;
        endfunction

        // Work out the result for one accepted triangle
        function void note_triangle(logic [DW_IN-1:0] d);
            logic signed [127:0] v[3][3], e1[3], e2[3], n[3], pt[3], u[3], w[3];
            logic signed [127:0] num, den, q, cr, step;
            logic [127:0] an[3], mnum, mden;
            logic [255:0] quo;
            int ax0, ax1, cnt, j, p, s;
            bit side, nside;
            t_hit_word r;
            r = '{1'b0, 32'sd0, 32'sd0, 32'sd0};
            num = 0;
            den = 0;
            cnt = 0;
            for (int i = 0; i < 3; i++)
                for (int k = 0; k < 3; k++)
                    v[i][k] = $signed(d[(i*3+k)*CW +: CW]);
            for (int k = 0; k < 3; k++) begin
                e1[k] = v[1][k] - v[0][k];
                e2[k] = v[2][k] - v[0][k];
            end
            // face normal, rescaled toward zero
            for (int k = 0; k < 3; k++) begin
                p = (k + 1) % 3;
                s = (k + 2) % 3;
                n[k] = (e1[p] * e2[s] - e1[s] * e2[p]) / 65536;
            end
            for (int k = 0; k < 3; k++) begin
                den = den + n[k] * ray[3+k];
                num = num + n[k] * (v[0][k] - ray[k]);
            end
            if (den == 0) begin
                owed.push_back(r);
                return;
            end
            mnum = num < 0 ? -num : num;
            mden = den < 0 ? -den : den;
            quo = ({128'd0, mnum} << FB) / {128'd0, mden};
            if (quo >= (256'd1 << 63)) q = (128'sd1 <<< 63) - 1;
            else q = $signed({1'b0, quo[126:0]});
            if (q != 0 && ((num < 0) != (den < 0))) begin
                owed.push_back(r);
                return;
            end
            // point on the ray, clamped for the crossing test
            for (int k = 0; k < 3; k++) begin
                step = (ray[3+k] * q) / 65536;
                pt[k] = ray[k] + step;
                if (pt[k] > (128'sd1 <<< 32)) pt[k] = 128'sd1 <<< 32;
                if (pt[k] < -(128'sd1 <<< 32)) pt[k] = -(128'sd1 <<< 32);
            end
            for (int k = 0; k < 3; k++) an[k] = n[k] < 0 ? -n[k] : n[k];
            if (an[0] >= an[1] && an[0] >= an[2]) begin
                ax0 = 1; ax1 = 2;
            end else if (an[1] >= an[2]) begin
                ax0 = 0; ax1 = 2;
            end else begin
                ax0 = 0; ax1 = 1;
            end
            for (int i = 0; i < 3; i++) begin
                u[i] = v[i][ax0] - pt[ax0];
                w[i] = v[i][ax1] - pt[ax1];
            end
            // count crossings of the positive u half axis
            side = w[0] < 0;
            for (int i = 0; i < 3; i++) begin
                j = (i + 1) % 3;
                nside = w[j] < 0;
                if (side != nside) begin
                    if (u[i] > 0 && u[j] > 0) begin
                        cnt++;
                    end else if (u[i] > 0 || u[j] > 0) begin
                        cr = u[i] * w[j] - w[i] * u[j];
                        if (cr != 0 && ((cr < 0) == ((w[j] - w[i]) < 0))) cnt++;
                    end
                    side = nside;
                end
            end
            if (cnt % 2 == 1) begin
                r.hit = 1'b1;
                for (int k = 0; k < 3; k++) begin
                    if (pt[k] > 128'sh7fffffff) pt[k] = 128'sh7fffffff;
                    if (pt[k] < -128'sh80000000) pt[k] = -128'sh80000000;
                end
                r.px = pt[0][31:0];
                r.py = pt[1][31:0];
                r.pz = pt[2][31:0];
            end
            owed.push_back(r);
        endfunction

        // Compare one result word with the oldest owed result
        function void check_word(logic [DW_OUT-1:0] d);
            t_hit_word e;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, d);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (d[0] !== e.hit) begin
                $display("%0t: hit expected %b actual %b", $time, e.hit, d[0]);
                errors++;
            end
            if (d[32:1] !== e.px) begin
                $display("%0t: hit_x expected %h actual %h", $time, e.px, d[32:1]);
                errors++;
            end
            if (d[64:33] !== e.py) begin
                $display("%0t: hit_y expected %h actual %h", $time, e.py, d[64:33]);
                errors++;
            end
            if (d[96:65] !== e.pz) begin
                $display("%0t: hit_z expected %h actual %h", $time, e.pz, d[96:65]);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
    logic [DW_IN-1:0]  i_s_axis_tdata;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    // hit, hit_x, hit_y, hit_z from bit 0 up, zero padded
    logic [DW_OUT-1:0] o_m_axis_tdata;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [CW-1:0]     i_cfg_data;

    t_hit_scoreboard sb;
    bit     quiet;
    bit     hold_go;
    int     stall_left;
    longint cycles;

    ray_triangle_intersection i_dut (.*);

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = REG_ORIGIN_X;
        i_cfg_data = '0;
        quiet = 1'b0;
        hold_go = 1'b0;
        stall_left = 0;
        cycles = 0;
        sb = new();
    end

    always #5 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Note accepted triangles and check result words
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) sb.note_triangle(i_s_axis_tdata);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) sb.check_word(o_m_axis_tdata);
    end

    // Receiver: random stall bursts and one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_go) begin
            hold_go = 1'b0;
            stall_left <= 400;
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(0, 18);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [DW_IN-1:0] pack_tri(input longint c[9]);
        logic [DW_IN-1:0] d;
        d = '0;
        for (int i = 0; i < 9; i++) d[i*CW +: CW] = c[i][CW-1:0];
        return d;
    endfunction

    // Offer one triangle after a random idle gap unless quiet; wait for acceptance
    task automatic send_triangle(input logic [DW_IN-1:0] d);
        int gap;
        gap = (!quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= d;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.owed.size() > 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_AW-1:0] idx, input logic [CW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Load a whole ray; pass through an unused index as well
    task automatic load_ray(input longint r[6]);
        drain();
        cfg_write(CFG_ADDR_UNUSED, $urandom());
        for (int k = 0; k < 6; k++) cfg_write(t_reg'(k), r[k][CW-1:0]);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic longint pick_extreme();
        case ($urandom_range(0, 4))
            0: return 64'sh7fffffff;
            1: return -64'sh80000000;
            2: return 0;
            3: return 1;
            default: return -1;
        endcase
    endfunction

    // Random triangle: mostly placed around a point on the ray, the rest noise
    task automatic random_triangle();
        longint c[9], t, ctr[3];
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            t = $urandom_range(0, 1) ? $urandom_range(0, 1 << 21)
                                     : -longint'($urandom_range(0, 1 << 17));
            for (int k = 0; k < 3; k++)
                ctr[k] = longint'(sb.ray[k]) + ((longint'(sb.ray[3+k]) * t) >>> FB);
            for (int i = 0; i < 9; i++)
                c[i] = ctr[i%3] + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        end else if (kind <= 7) begin
            for (int i = 0; i < 9; i++) c[i] = longint'($signed($urandom()));
        end else if (kind == 8) begin
            for (int i = 0; i < 9; i++) c[i] = pick_extreme();
        end else begin
            // degenerate: a repeated vertex
            for (int i = 0; i < 6; i++) c[i] = longint'($signed($urandom()));
            for (int i = 6; i < 9; i++) c[i] = c[i-3];
        end
        send_triangle(pack_tri(c));
    endtask

    localparam longint ONE = 65536;

    initial begin
        longint tri_set[14][9];
        longint rays[7][6];
        @(posedge i_clk);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed triangles against the reset ray
        tri_set = '{
            '{-ONE, -ONE, -ONE,  ONE, -ONE, -ONE,  0,  ONE, -ONE},    // hit below
            '{-ONE, -ONE,  ONE,  ONE, -ONE,  ONE,  0,  ONE,  ONE},    // behind origin
            '{ 0, -ONE, -ONE,  0,  ONE, -ONE,  0,  0, -2*ONE},        // parallel
            '{ 5*ONE, 0, -ONE, 7*ONE, 0, -ONE, 6*ONE, ONE, -ONE},     // off to the side
            '{ 0, 0, 0, 0, 0, 0, 0, 0, 0},                            // degenerate
            '{64'sh7fffffff, 64'sh7fffffff, 64'sh7fffffff, 64'sh7fffffff,
              64'sh7fffffff, 64'sh7fffffff, 64'sh7fffffff, 64'sh7fffffff, 64'sh7fffffff},
            '{-64'sh80000000, -64'sh80000000, -64'sh80000000, -64'sh80000000,
              -64'sh80000000, -64'sh80000000, -64'sh80000000, -64'sh80000000,
              -64'sh80000000},
            '{-64'sh80000000, -64'sh80000000, -ONE, 64'sh7fffffff, -64'sh80000000,
              -ONE, 0, 64'sh7fffffff, -ONE},                          // huge hit
            '{ ONE, 0, 0, 0, ONE, 0, 0, 0, ONE},                      // normal axis tie
            '{ ONE, ONE, 0, -ONE, ONE, 0, 0, -ONE, 0},                // tie x/y free
            '{-1000*ONE, -1000*ONE, 1, 1000*ONE, -1000*ONE, -1,
              0, 1000*ONE, 0},                                        // t near zero
            '{ 0, 0, -ONE, ONE, 0, -ONE, 0, ONE, -ONE},               // vertex on ray
            '{-ONE, 0, -ONE, ONE, 0, -ONE, 0, ONE, -ONE},             // edge on ray
            '{ ONE, ONE, -64'sh80000000, -ONE, ONE, -64'sh80000000,
              0, -ONE, 64'sh7fffffff}                                 // steep plane
        };
        foreach (tri_set[i]) send_triangle(pack_tri(tri_set[i]));

        rays = '{
            '{0, 0, 0, ONE, ONE/3, -ONE/5},
            '{3*ONE, -2*ONE, 5*ONE, -ONE/2, 2*ONE, ONE/7},
            '{-ONE, 4*ONE, 2*ONE, ONE/9, -ONE/4, -3*ONE},
            '{64'sh7fffffff, 64'sh7fffffff, 64'sh7fffffff,
              64'sh7fffffff, 64'sh7fffffff, 64'sh7fffffff},
            '{-64'sh80000000, -64'sh80000000, -64'sh80000000,
              -64'sh80000000, -64'sh80000000, -64'sh80000000},
            '{0, 0, 0, 0, 0, 0},
            '{ONE/2, -ONE/2, 0, 1, -1, ONE}
        };

        // Random phases across several rays
        for (int ph = 0; ph < 7; ph++) begin
            load_ray(rays[ph]);
            if (ph == 6) quiet = 1'b1;
            for (int n = 0; n < 76; n++) begin
                if (ph == 1 && n == 10) hold_go = 1'b1;
                if (ph == 2 && n == 40) begin
                    i_s_axis_tvalid <= 1'b0;
                    while (sb.owed.size() > 0) @(posedge i_clk);
                end
                random_triangle();
            end
        end

        // Wait out the pipeline, then report
        i_s_axis_tvalid <= 1'b0;
        while (sb.owed.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
